FILE: rtl/core/id_range_acceptance_filter_macros.svh
// assertion macros for the id range acceptance filter
// expects i_clk and i_rst_n in the scope of each use
`ifndef ID_RANGE_ACCEPTANCE_FILTER_MACROS_SVH
`define ID_RANGE_ACCEPTANCE_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("id range filter: assertion failed");
// next-cycle implication
`define IRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("id range filter: assertion failed");
`else
`define IRA_ASSERT_NOW(lbl, ante, cons)
`define IRA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/ira_pkg.sv
// shared types and constants for the id range acceptance filter
// no dependencies
`default_nettype none

package ira_pkg;

    localparam int ID_BITS  = 16;
    localparam int CNT_BITS = 5;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_MERGE = 2'd2,
        CMD_TEST  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [ID_BITS-1:0] range_low;
        logic [ID_BITS-1:0] range_high;
        logic [ID_BITS-1:0] message_id;
    } t_in;

    typedef struct packed {
        logic                accept;
        t_status             status;
        logic [CNT_BITS-1:0] entry_count;
    } t_out;

    typedef struct packed {
        logic [ID_BITS-1:0] lo;
        logic [ID_BITS-1:0] hi;
    } t_entry;

    // range that passes every id, held in entry 0 after reset
    localparam t_entry ENTRY_RST = '{lo: '0, hi: '1};

    typedef enum logic {
        CMP_GT    = 1'b0,
        CMP_REACH = 1'b1
    } t_cmp_op;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_tbl_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/id_range_acceptance_filter.sv
// Merge sorts the stored ranges by low bound and joins overlapping or adjacent ones;
// with fewer than two stored ranges it leaves the table unchanged.
// One transaction at a time; busy stays high until the result is strobed, and a new
// transaction can be taken in the strobe cycle. All table reads share one memory read
// port, all compares one compare unit. Synchronous reset leaves one range passing every id.
`default_nettype none

`include "id_range_acceptance_filter_macros.svh"

module id_range_acceptance_filter import ira_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_valid,
    output t_out o_result
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_ADD     = 15'b000000000000010,
        S_FIN     = 15'b000000000000100,
        S_SRT_KEY = 15'b000000000001000,
        S_SRT_LD  = 15'b000000000010000,
        S_SRT_CMP = 15'b000000000100000,
        S_SRT_PUT = 15'b000000001000000,
        S_MRG_RD0 = 15'b000000010000000,
        S_MRG_LD0 = 15'b000000100000000,
        S_MRG_C1  = 15'b000001000000000,
        S_MRG_C2  = 15'b000010000000000,
        S_MRG_END = 15'b000100000000000,
        S_TST_RD  = 15'b001000000000000,
        S_TST_C1  = 15'b010000000000000,
        S_TST_C2  = 15'b100000000000000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_ovld, n_ovld;
    t_out               r_out, n_out;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    logic [ID_BITS-1:0] r_lo, n_lo;
    logic [ID_BITS-1:0] r_hi, n_hi;
    logic [ID_BITS-1:0] r_id, n_id;
    t_entry             r_key, n_key;
    t_entry             r_cur, n_cur;
    logic               r_acc, n_acc;
    t_status            r_st, n_st;

    logic [CW-1:0]      nxt_i, prv_i, nxt_j, prv_j;
    t_cmp_op            cmp_op;
    logic [ID_BITS-1:0] cmp_a, cmp_b;
    logic               cmp_gt;
    t_tbl_ctl           tbl_ctl;
    logic [AW-1:0]      waddr, raddr;
    t_entry             wdata, rdata;

    assign nxt_i = r_i + CW'(1);
    assign prv_i = r_i - CW'(1);
    assign nxt_j = r_j + CW'(1);
    assign prv_j = r_j - CW'(1);

    ira_cmp u_cmp (
        .i_op (cmp_op),
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_gt (cmp_gt)
    );

    ira_table #(.DEPTH(MAX_ENTRIES)) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tbl_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovld  = 1'b0;
        n_out   = r_out;
        n_i     = r_i;
        n_j     = r_j;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_id    = r_id;
        n_key   = r_key;
        n_cur   = r_cur;
        n_acc   = r_acc;
        n_st    = r_st;
        tbl_ctl = '0;
        waddr   = r_j[AW-1:0];
        wdata   = r_cur;
        raddr   = r_i[AW-1:0];
        cmp_op  = CMP_GT;
        cmp_a   = r_id;
        cmp_b   = rdata.hi;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_lo  = i_item.range_low;
                    n_hi  = i_item.range_high;
                    n_id  = i_item.message_id;
                    n_acc = 1'b0;
                    n_st  = ST_OK;
                    case (i_item.cmd)
                        CMD_BEGIN: begin
                            n_cnt   = '0;
                            n_state = S_FIN;
                        end
                        CMD_ADD: begin
                            n_state = S_ADD;
                        end
                        CMD_MERGE: begin
                            if (r_cnt > CW'(1)) begin
                                n_i     = CW'(1);
                                n_state = S_SRT_KEY;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        CMD_TEST: begin
                            n_i     = '0;
                            n_state = (r_cnt == '0) ? S_FIN : S_TST_RD;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_ADD: begin
                cmp_a = r_lo;
                cmp_b = r_hi;
                if (cmp_gt) begin
                    n_st = ST_ORDER;
                end else if (r_cnt == CW'(MAX_ENTRIES)) begin
                    n_st = ST_FULL;
                end else begin
                    tbl_ctl.wr_en = 1'b1;
                    waddr         = r_cnt[AW-1:0];
                    wdata         = '{lo: r_lo, hi: r_hi};
                    n_cnt         = r_cnt + CW'(1);
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                n_ovld  = 1'b1;
                n_out   = '{accept: r_acc, status: r_st, entry_count: CNT_BITS'(r_cnt)};
                n_state = S_IDLE;
            end
            // insertion sort: r_i is the key slot, r_j the slot being compared
            S_SRT_KEY: begin
                tbl_ctl.rd_en = 1'b1;
                n_state       = S_SRT_LD;
            end
            S_SRT_LD: begin
                n_key         = rdata;
                n_j           = prv_i;
                tbl_ctl.rd_en = 1'b1;
                raddr         = prv_i[AW-1:0];
                n_state       = S_SRT_CMP;
            end
            S_SRT_CMP: begin
                cmp_a         = rdata.lo;
                cmp_b         = r_key.lo;
                tbl_ctl.wr_en = 1'b1;
                waddr         = nxt_j[AW-1:0];
                if (cmp_gt) begin
                    wdata = rdata;
                    if (r_j == '0) begin
                        n_state = S_SRT_PUT;
                    end else begin
                        n_j           = prv_j;
                        tbl_ctl.rd_en = 1'b1;
                        raddr         = prv_j[AW-1:0];
                    end
                end else begin
                    wdata   = r_key;
                    n_i     = nxt_i;
                    n_state = (nxt_i == r_cnt) ? S_MRG_RD0 : S_SRT_KEY;
                end
            end
            S_SRT_PUT: begin
                tbl_ctl.wr_en = 1'b1;
                wdata         = r_key;
                n_i           = nxt_i;
                n_state       = (nxt_i == r_cnt) ? S_MRG_RD0 : S_SRT_KEY;
            end
            // merge: r_cur is the open range, r_j its slot, r_i the next entry read
            S_MRG_RD0: begin
                tbl_ctl.rd_en = 1'b1;
                raddr         = '0;
                n_i           = CW'(1);
                n_state       = S_MRG_LD0;
            end
            S_MRG_LD0: begin
                n_cur         = rdata;
                n_j           = '0;
                tbl_ctl.rd_en = 1'b1;
                n_state       = S_MRG_C1;
            end
            S_MRG_C1: begin
                cmp_op = CMP_REACH;
                cmp_a  = rdata.lo;
                cmp_b  = r_cur.hi;
                if (cmp_gt) begin
                    tbl_ctl.wr_en = 1'b1;
                    n_j           = nxt_j;
                    n_cur         = rdata;
                    n_i           = nxt_i;
                    if (nxt_i == r_cnt) begin
                        n_state = S_MRG_END;
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        raddr         = nxt_i[AW-1:0];
                    end
                end else begin
                    n_state = S_MRG_C2;
                end
            end
            S_MRG_C2: begin
                cmp_a = rdata.hi;
                cmp_b = r_cur.hi;
                if (cmp_gt) begin
                    n_cur.hi = rdata.hi;
                end
                n_i = nxt_i;
                if (nxt_i == r_cnt) begin
                    n_state = S_MRG_END;
                end else begin
                    tbl_ctl.rd_en = 1'b1;
                    raddr         = nxt_i[AW-1:0];
                    n_state       = S_MRG_C1;
                end
            end
            S_MRG_END: begin
                tbl_ctl.wr_en = 1'b1;
                n_cnt         = nxt_j;
                n_state       = S_FIN;
            end
            S_TST_RD: begin
                tbl_ctl.rd_en = 1'b1;
                n_state       = S_TST_C1;
            end
            S_TST_C1: begin
                if (cmp_gt) begin
                    n_i = nxt_i;
                    if (nxt_i == r_cnt) begin
                        n_acc   = 1'b0;
                        n_state = S_FIN;
                    end else begin
                        tbl_ctl.rd_en = 1'b1;
                        raddr         = nxt_i[AW-1:0];
                    end
                end else begin
                    n_state = S_TST_C2;
                end
            end
            S_TST_C2: begin
                cmp_a   = rdata.lo;
                cmp_b   = r_id;
                n_acc   = !cmp_gt;
                n_state = S_FIN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= CW'(1);
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_i   <= n_i;
        r_j   <= n_j;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_id  <= n_id;
        r_key <= n_key;
        r_cur <= n_cur;
        r_acc <= n_acc;
        r_st  <= n_st;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_ovld;
    assign o_result = r_out;

    `IRA_ASSERT_NEXT(a_take_busy, start && !busy, busy)
    `IRA_ASSERT_NEXT(a_fin_strobe, r_state == S_FIN, o_valid)
    `IRA_ASSERT_NOW(a_strobe_idle, o_valid, r_state == S_IDLE)
    `IRA_ASSERT_NOW(a_cnt_range, 1'b1, r_cnt <= CW'(MAX_ENTRIES))
    `IRA_ASSERT_NOW(a_accept_ok, o_valid && o_result.accept, o_result.status == ST_OK)

endmodule

`default_nettype wire

FILE: rtl/core/ira_cmp.sv
// shared magnitude compare unit: a > b, or a > b + 1 for the touch test
// depends on ira_pkg
`default_nettype none

module ira_cmp import ira_pkg::*; (
    input  t_cmp_op            i_op,
    input  logic [ID_BITS-1:0] i_a,
    input  logic [ID_BITS-1:0] i_b,
    output logic               o_gt
);

    logic [ID_BITS:0] a_ext;
    logic [ID_BITS:0] rhs;

    // one bit wider so that an all-ones bound reaches nothing above it
    assign a_ext = {1'b0, i_a};
    assign rhs   = (i_op == CMP_REACH) ? ({1'b0, i_b} + {{ID_BITS{1'b0}}, 1'b1})
                                       : {1'b0, i_b};
    assign o_gt  = a_ext > rhs;

endmodule

`default_nettype wire

FILE: rtl/core/ira_table.sv
// range table memory, one write and one registered read port
// entry 0 reads as the full range until first written; depends on ira_pkg
`default_nettype none

module ira_table import ira_pkg::*; #(
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_tbl_ctl      i_ctl,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_q;
    logic   r_dflt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dflt <= 1'b1;
        end else if (i_ctl.wr_en && i_waddr == '0) begin
            r_dflt <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q <= (i_raddr == '0 && r_dflt) ? ENTRY_RST : r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire
